FILE: sv/srrw_pkg.sv
// srrw_pkg: shared constants, codes and types for the selective-repeat
// receive window. No dependencies; used by every module in sv/.
package srrw_pkg;

    // Default configuration
    localparam int WINDOW_DEPTH_DEF = 8;
    localparam int SEQ_WIDTH_DEF    = 16;

    // Packet id field: 16-bit signed, stored ids are non-negative
    localparam int ID_W  = 16;
    localparam int MAG_W = ID_W - 1;

    // Output sequence field width
    localparam int SEQ_OUT_W = 16;

    // Scenario codes and the ids that the drop hook targets
    localparam logic [1:0]             SCEN_DUPACK     = 2'd2;
    localparam logic [1:0]             SCEN_TIMEOUT    = 2'd3;
    localparam logic signed [ID_W-1:0] DROP_ID_DUPACK  = 16'sd7;
    localparam logic signed [ID_W-1:0] DROP_ID_TIMEOUT = 16'sd6;

    // Result kinds
    localparam logic KIND_RELEASE = 1'b0;
    localparam logic KIND_ACK     = 1'b1;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_MOD,
        S_READ,
        S_CHECK
    } t_state;

    // Slot store commands
    typedef struct packed {
        logic wr_en;
        logic clr_en;
    } t_slot_cmd;

endpackage

FILE: sv/srrw_rem_unit.sv
// srrw_rem_unit: slot index of a packet id (id mod the window depth), found by
// a reciprocal multiply and then a low-bit correction. Uses srrw_pkg.
module srrw_rem_unit #(
    parameter int DEPTH = srrw_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [srrw_pkg::MAG_W-1:0] i_value,
    output logic                       o_done,
    output logic [$clog2(DEPTH)-1:0]   o_rem
);

    localparam int SW = $clog2(DEPTH);
    localparam int SH = srrw_pkg::MAG_W + SW;
    localparam int RW = srrw_pkg::MAG_W + 2;
    localparam int PW = srrw_pkg::MAG_W + RW;
    localparam logic [RW-1:0] RECIP =
        RW'(((longint'(1) << SH) + longint'(DEPTH - 1)) / longint'(DEPTH));
    localparam logic [SW-1:0] DEPTH_LO = SW'(DEPTH);

    logic [srrw_pkg::MAG_W-1:0] r_value;
    logic [SW-1:0]              r_quot_lo;
    logic [SW-1:0]              r_rem;
    logic                       r_phase;
    logic                       r_busy;
    logic                       r_done;
    logic [PW-1:0]              prod;
    logic [SW-1:0]              quot_lo;
    logic [SW-1:0]              qd_lo;

    // Quotient: id times the scaled reciprocal, exact for any 15-bit id
    assign prod    = PW'(r_value) * PW'(RECIP);
    assign quot_lo = prod[SH +: SW];
    // The remainder is below the depth, so only the low bits are needed
    assign qd_lo   = r_quot_lo * DEPTH_LO;

    // Two-step sequence and completion pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_phase <= 1'b0;
            end else if (r_busy) begin
                r_phase <= 1'b1;
                if (r_phase) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_value <= i_value;
        end else if (r_busy) begin
            if (!r_phase) begin
                r_quot_lo <= quot_lo;
            end else begin
                r_rem <= r_value[SW-1:0] - qd_lo;
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

FILE: sv/srrw_slot_mem.sv
// srrw_slot_mem: window slot store, id array with registered read and a
// valid flop per slot (cleared at reset). Uses srrw_pkg.
module srrw_slot_mem #(
    parameter int DEPTH = srrw_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  srrw_pkg::t_slot_cmd        i_cmd,
    input  logic [$clog2(DEPTH)-1:0]   i_wr_addr,
    input  logic [srrw_pkg::MAG_W-1:0] i_wr_id,
    input  logic [$clog2(DEPTH)-1:0]   i_clr_addr,
    input  logic [$clog2(DEPTH)-1:0]   i_rd_addr,
    output logic [srrw_pkg::MAG_W-1:0] o_rd_id,
    output logic                       o_rd_valid
);

    logic [srrw_pkg::MAG_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]           r_valid;
    logic [srrw_pkg::MAG_W-1:0] r_rd_id;
    logic                       r_rd_valid;

    // Valid bits: set on store, cleared on release
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_cmd.wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_cmd.clr_en) begin
                r_valid[i_clr_addr] <= 1'b0;
            end
            r_rd_valid <= r_valid[i_rd_addr];
        end
    end

    // Id array, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_id;
        end
        r_rd_id <= r_mem[i_rd_addr];
    end

    assign o_rd_id    = r_rd_id;
    assign o_rd_valid = r_rd_valid;

endmodule

FILE: sv/selective_repeat_receive_window_unit.sv
// selective_repeat_receive_window_unit: top level, sequencer, base counter
// and output register. Uses srrw_pkg, srrw_rem_unit and srrw_slot_mem.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one arriving packet:
//   i_packet_id (signed, negative = no id) and i_scenario. Output channel
//   (o_out_valid / i_out_stall) carries results: zero or more in-order
//   releases (o_kind = 0) and then one cumulative ACK (o_kind = 1,
//   o_last = 1) holding base - 1.
//   One packet is processed at a time; o_in_stall is high while it runs.
//   A non-negative id goes through the remainder unit (reciprocal
//   multiply, low-bit correction, done cycle) to find its slot, then a
//   memory read. Each release then takes a check and a re-read of the
//   slot memory port, and the ACK is loaded in the final check; a
//   negative id skips the remainder unit. The next packet can transfer
//   in the cycle after the ACK load.
//   A packet taken by the drop hook is absorbed in its transfer cycle.
//   The output register holds each result while i_out_stall is high; the
//   sequencer waits in its check state until the register is free.
//   Reset empties the window at once (valid flops), zeroes the base and
//   arms the drop hook; there is no clearing pass.
module selective_repeat_receive_window_unit #(
    parameter int WINDOW_DEPTH = srrw_pkg::WINDOW_DEPTH_DEF,
    parameter int SEQ_WIDTH    = srrw_pkg::SEQ_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic signed [srrw_pkg::ID_W-1:0]   i_packet_id,
    input  logic [1:0]                         i_scenario,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_kind,
    output logic signed [srrw_pkg::SEQ_OUT_W-1:0] o_seq_value,
    output logic                               o_last
);

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int BW = SEQ_WIDTH - 1;
    localparam int XW = (BW > srrw_pkg::MAG_W) ? BW : srrw_pkg::MAG_W;
    localparam int EW = (BW > srrw_pkg::SEQ_OUT_W) ? BW : srrw_pkg::SEQ_OUT_W;

    srrw_pkg::t_state r_state;
    srrw_pkg::t_state n_state;

    logic [BW-1:0]              r_base;
    logic [AW-1:0]              r_base_slot;
    logic                       r_armed;
    logic [srrw_pkg::MAG_W-1:0] r_mag;

    logic                              r_out_valid;
    logic                              r_out_kind;
    logic [srrw_pkg::SEQ_OUT_W-1:0]    r_out_seq;
    logic                              r_out_last;

    logic                       in_fire;
    logic                       drop_hit;
    logic                       id_neg;
    logic                       out_free;
    logic                       hit;
    logic                       rem_start;
    logic                       rem_done;
    logic [AW-1:0]              rem_slot;
    logic                       disarm;
    logic                       out_load;
    logic                       advance;
    srrw_pkg::t_slot_cmd        slot_cmd;
    logic [srrw_pkg::MAG_W-1:0] rd_id;
    logic                       rd_valid;
    logic [EW-1:0]              base_ext;
    logic [srrw_pkg::SEQ_OUT_W-1:0] base_seq;

    // Input side decode
    assign o_in_stall = (r_state != srrw_pkg::S_IDLE);
    assign in_fire    = i_in_valid && !o_in_stall;
    assign id_neg     = i_packet_id[srrw_pkg::ID_W-1];
    assign drop_hit   = r_armed &&
                        ((i_scenario == srrw_pkg::SCEN_DUPACK &&
                          i_packet_id == srrw_pkg::DROP_ID_DUPACK) ||
                         (i_scenario == srrw_pkg::SCEN_TIMEOUT &&
                          i_packet_id == srrw_pkg::DROP_ID_TIMEOUT));

    // Slot match at the base and output register availability
    assign hit      = rd_valid && (XW'(rd_id) == XW'(r_base));
    assign out_free = !r_out_valid || !i_out_stall;
    assign base_ext = EW'(r_base);
    assign base_seq = base_ext[srrw_pkg::SEQ_OUT_W-1:0];

    // Remainder unit: slot index of an arriving id
    srrw_rem_unit #(
        .DEPTH (WINDOW_DEPTH)
    ) u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (rem_start),
        .i_value (i_packet_id[srrw_pkg::MAG_W-1:0]),
        .o_done  (rem_done),
        .o_rem   (rem_slot)
    );

    // Window slot store
    srrw_slot_mem #(
        .DEPTH (WINDOW_DEPTH)
    ) u_slots (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (slot_cmd),
        .i_wr_addr  (rem_slot),
        .i_wr_id    (r_mag),
        .i_clr_addr (r_base_slot),
        .i_rd_addr  (r_base_slot),
        .o_rd_id    (rd_id),
        .o_rd_valid (rd_valid)
    );

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            srrw_pkg::S_IDLE: begin
                if (in_fire && !drop_hit) begin
                    n_state = id_neg ? srrw_pkg::S_READ : srrw_pkg::S_MOD;
                end
            end
            srrw_pkg::S_MOD: begin
                if (rem_done) begin
                    n_state = srrw_pkg::S_READ;
                end
            end
            srrw_pkg::S_READ: begin
                n_state = srrw_pkg::S_CHECK;
            end
            srrw_pkg::S_CHECK: begin
                if (out_free) begin
                    n_state = hit ? srrw_pkg::S_READ : srrw_pkg::S_IDLE;
                end
            end
            default: n_state = srrw_pkg::S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        rem_start       = 1'b0;
        disarm          = 1'b0;
        out_load        = 1'b0;
        advance         = 1'b0;
        slot_cmd.wr_en  = 1'b0;
        slot_cmd.clr_en = 1'b0;
        unique case (r_state)
            srrw_pkg::S_IDLE: begin
                rem_start = in_fire && !drop_hit && !id_neg;
                disarm    = in_fire && drop_hit;
            end
            srrw_pkg::S_MOD: begin
                slot_cmd.wr_en = rem_done;
            end
            srrw_pkg::S_READ: begin
                rem_start = 1'b0;
            end
            srrw_pkg::S_CHECK: begin
                out_load        = out_free;
                advance         = out_free && hit;
                slot_cmd.clr_en = out_free && hit;
            end
            default: begin
                rem_start = 1'b0;
            end
        endcase
    end

    // Control state: sequencer, base, hook, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= srrw_pkg::S_IDLE;
            r_base      <= '0;
            r_base_slot <= '0;
            r_armed     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (disarm) begin
                r_armed <= 1'b0;
            end
            if (advance) begin
                r_base <= r_base + BW'(1);
                if (r_base == '1 || r_base_slot == AW'(WINDOW_DEPTH - 1)) begin
                    r_base_slot <= '0;
                end else begin
                    r_base_slot <= r_base_slot + AW'(1);
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: captured id and output result
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_mag <= i_packet_id[srrw_pkg::MAG_W-1:0];
        end
        if (out_load) begin
            r_out_kind <= hit ? srrw_pkg::KIND_RELEASE : srrw_pkg::KIND_ACK;
            r_out_seq  <= hit ? base_seq : base_seq - srrw_pkg::SEQ_OUT_W'(1);
            r_out_last <= !hit;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_out_kind;
    assign o_seq_value = r_out_seq;
    assign o_last      = r_out_last;

    // Checks
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> !(r_out_valid && i_out_stall))
        else $error("result loaded over a stalled result");

    a_rem_in_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rem_done |-> (r_state == srrw_pkg::S_MOD))
        else $error("remainder completed outside slot lookup");

    a_release_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == srrw_pkg::S_CHECK && out_free && hit) |=>
        (r_state == srrw_pkg::S_READ && r_base == BW'($past(r_base) + BW'(1))))
        else $error("release did not advance the base");

    a_ack_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == srrw_pkg::S_CHECK && out_free && !hit) |=>
        (r_state == srrw_pkg::S_IDLE && o_out_valid && o_last))
        else $error("ACK did not close the item");

endmodule

FILE: dv/selective_repeat_receive_window_unit_tb.sv
// selective_repeat_receive_window_unit_tb: self-checking bench for the receive window.
// Drives packets, predicts releases and ACKs, and compares every output transfer.
// Depends on srrw_pkg and selective_repeat_receive_window_unit.
module selective_repeat_receive_window_unit_tb;

    localparam int SLOT_COUNT       = srrw_pkg::WINDOW_DEPTH_DEF;
    localparam int RANDOM_PER_PHASE = 120;
    localparam int LONG_HOLD        = 300;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int DRAIN_CYCLES     = 40;
    localparam int MAX_REPORTS      = 100;

    // Scenario codes with no drop behavior
    localparam logic [1:0] SCEN_PLAIN     = 2'd0;
    localparam logic [1:0] SCEN_PLAIN_ALT = 2'd1;

    // How a directed row is checked
    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_ACK,
        CHK_DROP
    } t_check;

    typedef struct packed {
        logic [srrw_pkg::ID_W-1:0] id;
        logic [1:0]                scen;
        t_check                    chk;
        logic [srrw_pkg::ID_W-1:0] ack;
    } t_stim_row;

    typedef struct packed {
        logic                           kind;
        logic [srrw_pkg::SEQ_OUT_W-1:0] seq;
        logic                           last;
    } t_window_result;

    localparam int DIR_ROWS = 23;
    localparam t_stim_row DIRECTED [0:DIR_ROWS-1] = '{
        // empty window: no id, extremes, hook near misses, hook firing, spent hook
        '{16'hFFFF, SCEN_PLAIN,     CHK_ACK, 16'hFFFF},
        '{16'h8000, SCEN_PLAIN_ALT, CHK_ACK, 16'hFFFF},
        '{16'h7FFF, SCEN_PLAIN,     CHK_ACK, 16'hFFFF},
        '{srrw_pkg::DROP_ID_TIMEOUT, srrw_pkg::SCEN_DUPACK,  CHK_ACK,  16'hFFFF},
        '{srrw_pkg::DROP_ID_DUPACK,  srrw_pkg::SCEN_TIMEOUT, CHK_ACK,  16'hFFFF},
        '{srrw_pkg::DROP_ID_TIMEOUT, srrw_pkg::SCEN_TIMEOUT, CHK_DROP, 16'h0000},
        '{srrw_pkg::DROP_ID_DUPACK,  srrw_pkg::SCEN_DUPACK,  CHK_ACK,  16'hFFFF},
        // out of order arrivals, then the gap fill
        '{16'd3,  SCEN_PLAIN_ALT,         CHK_MODEL, 16'h0000},
        '{16'd2,  SCEN_PLAIN,             CHK_MODEL, 16'h0000},
        '{16'd1,  srrw_pkg::SCEN_DUPACK,  CHK_MODEL, 16'h0000},
        '{16'd0,  srrw_pkg::SCEN_TIMEOUT, CHK_MODEL, 16'h0000},
        '{16'd5,  SCEN_PLAIN,             CHK_MODEL, 16'h0000},
        '{16'd4,  SCEN_PLAIN_ALT,         CHK_MODEL, 16'h0000},
        // slot overwrite by an older id
        '{16'd16, SCEN_PLAIN,             CHK_MODEL, 16'h0000},
        '{16'd8,  SCEN_PLAIN,             CHK_MODEL, 16'h0000},
        // fill the whole window, then release all of it in one walk
        '{16'd16, SCEN_PLAIN_ALT,         CHK_MODEL, 16'h0000},
        '{16'd15, srrw_pkg::SCEN_DUPACK,  CHK_MODEL, 16'h0000},
        '{16'd14, srrw_pkg::SCEN_TIMEOUT, CHK_MODEL, 16'h0000},
        '{16'd13, SCEN_PLAIN,             CHK_MODEL, 16'h0000},
        '{16'd12, SCEN_PLAIN_ALT,         CHK_MODEL, 16'h0000},
        '{16'd11, srrw_pkg::SCEN_DUPACK,  CHK_MODEL, 16'h0000},
        '{16'd10, srrw_pkg::SCEN_TIMEOUT, CHK_MODEL, 16'h0000},
        '{16'd9,  SCEN_PLAIN,             CHK_MODEL, 16'h0000}
    };

    logic                                  i_clk;
    logic                                  i_rst_n     = 1'b0;
    logic                                  i_in_valid  = 1'b0;
    logic                                  o_in_stall;
    logic signed [srrw_pkg::ID_W-1:0]      i_packet_id = '0;
    logic [1:0]                            i_scenario  = SCEN_PLAIN;
    logic                                  o_out_valid;
    logic                                  i_out_stall = 1'b0;
    logic                                  o_kind;
    logic signed [srrw_pkg::SEQ_OUT_W-1:0] o_seq_value;
    logic                                  o_last;

    // Window predictor state
    logic        win_valid [SLOT_COUNT];
    logic [14:0] win_id [SLOT_COUNT];
    logic [14:0] win_base;
    logic        hook_armed;

    t_window_result expected_results [$];
    t_window_result want_result;

    int mismatch_count = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_req       = 0;
    int hold_seen      = 0;
    int hold_left      = 0;
    int quiet_cycles   = 0;

    selective_repeat_receive_window_unit #(
        .WINDOW_DEPTH (srrw_pkg::WINDOW_DEPTH_DEF),
        .SEQ_WIDTH    (srrw_pkg::SEQ_WIDTH_DEF)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_packet_id (i_packet_id),
        .i_scenario  (i_scenario),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_kind      (o_kind),
        .o_seq_value (o_seq_value),
        .o_last      (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what);
        if (mismatch_count < MAX_REPORTS) begin
            $display("MISMATCH at %0t: %s", $realtime, what);
        end
        mismatch_count++;
    endtask

    // Apply the drop hook, or store the packet, walk the window in order and finish
    // with the cumulative ACK. Results go to the queue only when keep is set.
    function automatic void window_predict(input logic [srrw_pkg::ID_W-1:0] id,
                                           input logic [1:0] scen, input logic keep);
        int idx;
        int g;
        t_window_result r;
        if (hook_armed && !id[srrw_pkg::ID_W-1] &&
            ((scen == srrw_pkg::SCEN_DUPACK && id == srrw_pkg::DROP_ID_DUPACK) ||
             (scen == srrw_pkg::SCEN_TIMEOUT && id == srrw_pkg::DROP_ID_TIMEOUT))) begin
            hook_armed = 1'b0;
            return;
        end
        if (!id[srrw_pkg::ID_W-1]) begin
            idx = int'(id[srrw_pkg::ID_W-2:0]) % SLOT_COUNT;
            win_valid[idx] = 1'b1;
            win_id[idx]    = id[srrw_pkg::ID_W-2:0];
        end
        for (g = 0; g < SLOT_COUNT; g++) begin
            idx = int'(win_base) % SLOT_COUNT;
            if (!win_valid[idx] || win_id[idx] != win_base) break;
            win_valid[idx] = 1'b0;
            r.kind = srrw_pkg::KIND_RELEASE;
            r.seq  = {1'b0, win_base};
            r.last = 1'b0;
            if (keep) expected_results.push_back(r);
            win_base = win_base + 15'd1;
        end
        r.kind = srrw_pkg::KIND_ACK;
        r.seq  = {1'b0, win_base} - 16'd1;
        r.last = 1'b1;
        if (keep) expected_results.push_back(r);
    endfunction

    // Offer one packet, wait for its transfer, then record what it should cause
    task automatic send_packet(input logic [srrw_pkg::ID_W-1:0] id, input logic [1:0] scen,
                               input t_check chk, input logic [srrw_pkg::ID_W-1:0] ack);
        t_window_result r;
        while ($urandom_range(99, 0) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_packet_id <= id;
        i_scenario  <= scen;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        window_predict(id, scen, chk == CHK_MODEL);
        if (chk == CHK_ACK) begin
            r.kind = srrw_pkg::KIND_ACK;
            r.seq  = ack;
            r.last = 1'b1;
            expected_results.push_back(r);
        end
    endtask

    // Sender goes quiet until every pending result has been seen
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    // Receiver: random stall, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99, 0) < recv_stall_pct);
        end
    end

    // Output checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind=%0d seq=%0d last=%0d",
                                          o_kind, o_seq_value, o_last));
            end else begin
                want_result = expected_results.pop_front();
                if (o_kind !== want_result.kind)
                    report_mismatch($sformatf("kind %0d, want %0d", o_kind, want_result.kind));
                if (o_seq_value !== $signed(want_result.seq))
                    report_mismatch($sformatf("seq_value %0d, want %0d",
                                              o_seq_value, $signed(want_result.seq)));
                if (o_last !== want_result.last)
                    report_mismatch($sformatf("last %0d, want %0d", o_last, want_result.last));
            end
        end
    end

    // Watchdog: cycles with no transfer on either channel
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int i;
        int phase;
        int k;
        int pick;
        logic [14:0] ahead;
        logic [srrw_pkg::ID_W-1:0] id;
        logic [1:0] scen;

        for (i = 0; i < SLOT_COUNT; i++) begin
            win_valid[i] = 1'b0;
            win_id[i]    = '0;
        end
        win_base   = '0;
        hook_armed = 1'b1;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows
        for (i = 0; i < DIR_ROWS; i++) begin
            send_packet(DIRECTED[i].id, DIRECTED[i].scen, DIRECTED[i].chk, DIRECTED[i].ack);
        end
        drain_results();

        // Random phases: none, sender idle, receiver stall, both
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
                1: begin send_idle_pct = 60; recv_stall_pct <= 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct <= 60; end
                default: begin send_idle_pct = 30; recv_stall_pct <= 30; end
            endcase
            for (k = 0; k < RANDOM_PER_PHASE; k++) begin
                // long receiver hold while packets keep coming
                if (phase == 0 && k == 10) hold_req <= hold_req + 1;
                if (phase == 0 && k == 60) drain_results();
                pick = $urandom_range(99, 0);
                scen = 2'($urandom_range(3, 0));
                if (pick < 70) begin
                    ahead = win_base + 15'($urandom_range(7, 0));
                    id = {1'b0, ahead};
                end else if (pick < 80) begin
                    ahead = win_base + 15'($urandom_range(40, 8));
                    id = {1'b0, ahead};
                end else if (pick < 88) begin
                    id = {1'b0, 15'($urandom)};
                end else if (pick < 95) begin
                    id = ($urandom_range(1, 0) == 0) ? 16'hFFFF : {1'b1, 15'($urandom)};
                end else if ($urandom_range(1, 0) == 0) begin
                    id = srrw_pkg::DROP_ID_DUPACK;
                    scen = srrw_pkg::SCEN_DUPACK;
                end else begin
                    id = srrw_pkg::DROP_ID_TIMEOUT;
                    scen = srrw_pkg::SCEN_TIMEOUT;
                end
                send_packet(id, scen, CHK_MODEL, '0);
            end
            drain_results();
        end

        send_idle_pct = 0;
        recv_stall_pct <= 0;
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/srrw_pkg.sv
sv/srrw_rem_unit.sv
sv/srrw_slot_mem.sv
sv/selective_repeat_receive_window_unit.sv
dv/selective_repeat_receive_window_unit_tb.sv
